### hdl/ps2mct_pkg.sv
// Shared types and constants for the PS/2 mouse packet cursor tracker.
// Used by the result and config interfaces and every module of the block; depends on nothing.
package ps2mct_pkg;

  // Default parameter values.
  localparam int COORD_BITS_DEF  = 13;
  localparam int CURSOR_SIZE_DEF = 4;

  // Screen size after reset.
  localparam int RESET_WIDTH  = 1024;
  localparam int RESET_HEIGHT = 768;

  // Configuration register index width and register map.
  localparam int CFG_IDX_BITS = 2;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1
  } cfg_reg_t;

  // Protocol constants of the mouse byte stream.
  localparam logic [7:0] ACK_BYTE       = 8'hFA;
  localparam int         HDR_SYNC_BIT   = 3;
  localparam logic [7:0] OVERFLOW_MASK  = 8'hC0;
  localparam logic [1:0] POS_FIRST      = 2'd0;
  localparam logic [1:0] POS_LAST       = 2'd2;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_ACK      = 3'd1,
    ST_STRAY    = 3'd2,
    ST_MOVED    = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  // One classified item handed from the front to the back.
  typedef struct packed {
    status_t    status;
    logic [7:0] header_byte;
    logic [7:0] x_byte;
    logic [7:0] y_byte;
  } item_t;

endpackage

### hdl/ps2mct_byte_if.sv
// Channel interface for raw mouse bytes (valid/ready plus one data byte).
// No dependency on ps2mct_pkg or on any other file.
interface ps2mct_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

### hdl/ps2mct_result_if.sv
// Channel interface for result items: status, cursor positions and packet bytes.
// Depends on ps2mct_pkg for the default coordinate width.
interface ps2mct_result_if #(
  parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            status;
  logic [COORD_BITS-1:0] cursor_x;
  logic [COORD_BITS-1:0] cursor_y;
  logic [COORD_BITS-1:0] prev_x;
  logic [COORD_BITS-1:0] prev_y;
  logic [7:0]            header_byte;
  logic [7:0]            x_byte;
  logic [7:0]            y_byte;

  modport source (output valid, output status, output cursor_x, output cursor_y,
                  output prev_x, output prev_y, output header_byte, output x_byte,
                  output y_byte, input ready);
  modport sink   (input valid, input status, input cursor_x, input cursor_y,
                  input prev_x, input prev_y, input header_byte, input x_byte,
                  input y_byte, output ready);
endinterface

### hdl/ps2mct_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on ps2mct_pkg for the index width and default data width.
interface ps2mct_cfg_if #(
  parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
);
  import ps2mct_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [COORD_BITS-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/ps2mct_front.sv
// Front part: accepts mouse bytes, tracks the packet position and classifies
// each item before it enters the queue. Depends on ps2mct_pkg and ps2mct_byte_if.
module ps2mct_front (
  input  logic                clk,
  input  logic                rst,
  ps2mct_byte_if.sink         mouse,
  input  logic                queue_full,
  output logic                push,
  output ps2mct_pkg::item_t   push_item
);
  import ps2mct_pkg::*;

  logic [1:0] byte_position;
  logic [1:0] byte_position_next;
  logic [7:0] packet_store [2];
  logic [1:0] pos_eff;
  logic       store_en;
  logic [7:0] byte_in;

  assign byte_in     = mouse.data_byte;
  assign mouse.ready = !queue_full;
  assign push        = mouse.valid && !queue_full;

  // An out-of-range position counts as the start of a packet.
  assign pos_eff = (byte_position > POS_LAST) ? POS_FIRST : byte_position;

  // Classify the byte against the current packet position.
  always_comb begin
    push_item          = '{status: ST_STORED, header_byte: 8'h00, x_byte: 8'h00,
                           y_byte: 8'h00};
    byte_position_next = pos_eff;
    store_en           = 1'b0;
    priority if (pos_eff == POS_FIRST && byte_in == ACK_BYTE) begin
      push_item.status = ST_ACK;
    end else if (pos_eff == POS_FIRST && !byte_in[HDR_SYNC_BIT]) begin
      push_item.status = ST_STRAY;
    end else if (pos_eff < POS_LAST) begin
      push_item.status   = ST_STORED;
      store_en           = 1'b1;
      byte_position_next = pos_eff + 2'd1;
    end else begin
      push_item.header_byte = packet_store[0];
      push_item.x_byte      = packet_store[1];
      push_item.y_byte      = byte_in;
      byte_position_next    = POS_FIRST;
      push_item.status      = ((packet_store[0] & OVERFLOW_MASK) == 8'h00) ?
                              ST_MOVED : ST_OVERFLOW;
    end
  end

  // Packet position counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_FIRST;
    end else if (push) begin
      byte_position <= byte_position_next;
    end
  end

  // Header and X bytes are held until the packet completes.
  always_ff @(posedge clk) begin
    if (push && store_en) begin
      packet_store[pos_eff[0]] <= byte_in;
    end
  end

endmodule

### hdl/ps2mct_queue.sv
// Short queue of classified items between the front and the back.
// Depends on ps2mct_pkg for the item type and depth.
module ps2mct_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ps2mct_pkg::item_t push_item,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output ps2mct_pkg::item_t head
);
  import ps2mct_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

  item_t               entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == (PTR_BITS + 1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Item storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

### hdl/ps2mct_back.sv
// Back part: holds screen size and cursor position, applies moves with clamping
// and registers each result item. Depends on ps2mct_pkg and the result/config interfaces.
module ps2mct_back #(
  parameter int COORD_BITS  = ps2mct_pkg::COORD_BITS_DEF,
  parameter int CURSOR_SIZE = ps2mct_pkg::CURSOR_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  input  ps2mct_pkg::item_t head,
  output logic              pop,
  ps2mct_cfg_if.sink        cfg,
  ps2mct_result_if.source   result
);
  import ps2mct_pkg::*;

  localparam int W = COORD_BITS + 2;
  localparam logic [COORD_BITS-1:0] RST_W = COORD_BITS'(RESET_WIDTH);
  localparam logic [COORD_BITS-1:0] RST_H = COORD_BITS'(RESET_HEIGHT);

  logic [COORD_BITS-1:0] screen_width;
  logic [COORD_BITS-1:0] screen_height;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [COORD_BITS-1:0] pos_x_next;
  logic [COORD_BITS-1:0] pos_y_next;
  logic signed [W-1:0]   delta_x;
  logic signed [W-1:0]   delta_y;
  logic                  is_move;

  // Add a signed delta and clamp to [0, size - CURSOR_SIZE].
  function automatic logic [COORD_BITS-1:0] move_axis(
    input logic [COORD_BITS-1:0] pos,
    input logic signed [W-1:0]   delta,
    input logic [COORD_BITS-1:0] size
  );
    logic signed [W-1:0] limit;
    logic signed [W-1:0] v;
    limit = $signed({2'b00, size}) - $signed(W'(CURSOR_SIZE));
    v     = $signed({2'b00, pos}) + delta;
    if (limit < 0) limit = '0;
    if (v < 0) v = '0;
    if (v > limit) v = limit;
    return v[COORD_BITS-1:0];
  endfunction

  // The Y axis of the mouse points up, so its delta is negated.
  assign delta_x = $signed({{(W-8){head.x_byte[7]}}, head.x_byte});
  assign delta_y = -$signed({{(W-8){head.y_byte[7]}}, head.y_byte});
  assign is_move = (head.status == ST_MOVED);

  assign pos_x_next = is_move ? move_axis(pos_x, delta_x, screen_width)  : pos_x;
  assign pos_y_next = is_move ? move_axis(pos_y, delta_y, screen_height) : pos_y;

  // Take an item whenever the output register is free or being emptied.
  assign pop       = !empty && (!result.valid || result.ready);
  assign cfg.ready = 1'b1;

  // Screen size and cursor position; a size write recenters its axis.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= RST_W;
      screen_height <= RST_H;
      pos_x         <= RST_W >> 1;
      pos_y         <= RST_H >> 1;
    end else begin
      if (pop) begin
        pos_x <= pos_x_next;
        pos_y <= pos_y_next;
      end
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_SCREEN_WIDTH: begin
            screen_width <= cfg.data;
            pos_x        <= cfg.data >> 1;
          end
          REG_SCREEN_HEIGHT: begin
            screen_height <= cfg.data;
            pos_y         <= cfg.data >> 1;
          end
          default: ;
        endcase
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (pop) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (pop) begin
      result.status      <= head.status;
      result.cursor_x    <= pos_x_next;
      result.cursor_y    <= pos_y_next;
      result.prev_x      <= pos_x;
      result.prev_y      <= pos_y;
      result.header_byte <= head.header_byte;
      result.x_byte      <= head.x_byte;
      result.y_byte      <= head.y_byte;
    end
  end

endmodule

### hdl/ps2_mouse_packet_cursor_tracker.sv
// PS/2 mouse packet decoder and cursor tracker, top level.
// Depends on ps2mct_pkg, the channel interfaces, ps2mct_front, ps2mct_queue and ps2mct_back.
//
// Raw mouse bytes enter on the mouse channel at up to one item per cycle while the queue
// is not full; every byte produces exactly one result item via the queue and the output
// register. The front tracks the three-byte packet position, reports acknowledge bytes
// and stray bytes at packet start with their own status, classifies overflow packets;
// a two-entry queue lets it keep accepting until full while the back is stalled. The
// back adds the X delta, subtracts the Y delta, clamps each axis to 0 .. screen size
// minus CURSOR_SIZE and registers the result, one item per cycle while the result
// channel is not stalled. Writing a screen size register sets the matching axis to half
// the size; configuration writes are accepted every cycle but belong between items only.
module ps2_mouse_packet_cursor_tracker #(
  parameter int COORD_BITS  = ps2mct_pkg::COORD_BITS_DEF,
  parameter int CURSOR_SIZE = ps2mct_pkg::CURSOR_SIZE_DEF
) (
  input  logic            clk,
  input  logic            rst,
  ps2mct_byte_if.sink     mouse,
  ps2mct_cfg_if.sink      cfg,
  ps2mct_result_if.source cursor
);
  import ps2mct_pkg::*;

  logic  push;
  logic  pop;
  logic  queue_full;
  logic  queue_empty;
  item_t push_item;
  item_t head;

  // Byte intake and classification.
  ps2mct_front u_front (
    .clk        (clk),
    .rst        (rst),
    .mouse      (mouse),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  // Queue between classification and cursor update.
  ps2mct_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (queue_full),
    .empty     (queue_empty),
    .head      (head)
  );

  // Cursor update and result register.
  ps2mct_back #(
    .COORD_BITS  (COORD_BITS),
    .CURSOR_SIZE (CURSOR_SIZE)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (queue_empty),
    .head   (head),
    .pop    (pop),
    .cfg    (cfg),
    .result (cursor)
  );

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the PS/2 mouse packet cursor tracker: a directed table, then
// random packet streams over several screen sizes, each result checked against a predictor.
// Depends on ps2mct_pkg, the three channel interfaces and ps2_mouse_packet_cursor_tracker.
module tb_top;
  import ps2mct_pkg::*;

  localparam int COORD_BITS   = COORD_BITS_DEF;
  localparam int CURSOR_SIZE  = CURSOR_SIZE_DEF;
  localparam int NUM_PHASES   = 9;
  localparam int PHASE_ITEMS  = 125;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_REPORTS  = 10;

  // Indexes outside the register map; writes to them must be ignored.
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_3 = 2'd3;
  localparam logic [7:0] SYNC_MASK = 8'(1 << HDR_SYNC_BIT);

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    status_t    status;
    coord_t     cursor_x;
    coord_t     cursor_y;
    coord_t     prev_x;
    coord_t     prev_y;
    logic [7:0] header_byte;
    logic [7:0] x_byte;
    logic [7:0] y_byte;
  } cursor_result_t;

  typedef struct packed {
    logic [7:0]     data;
    logic           typed;
    cursor_result_t want;
  } stim_row_t;

  localparam coord_t X0 = coord_t'(RESET_WIDTH / 2);
  localparam coord_t Y0 = coord_t'(RESET_HEIGHT / 2);

  // Directed bytes sent right after reset. Rows whose outcome is obvious from the reset
  // position carry their result; the others are left to the predictor.
  localparam stim_row_t DIRECTED_ROWS [0:24] = '{
    '{8'hFA, 1'b1, '{ST_ACK,      X0, Y0, X0, Y0, 8'h00, 8'h00, 8'h00}},
    '{8'h00, 1'b1, '{ST_STRAY,    X0, Y0, X0, Y0, 8'h00, 8'h00, 8'h00}},
    '{8'hF7, 1'b1, '{ST_STRAY,    X0, Y0, X0, Y0, 8'h00, 8'h00, 8'h00}},
    '{8'hC8, 1'b1, '{ST_STORED,   X0, Y0, X0, Y0, 8'h00, 8'h00, 8'h00}},
    '{8'h55, 1'b1, '{ST_STORED,   X0, Y0, X0, Y0, 8'h00, 8'h00, 8'h00}},
    '{8'hAA, 1'b1, '{ST_OVERFLOW, X0, Y0, X0, Y0, 8'hC8, 8'h55, 8'hAA}},
    '{8'h08, 1'b1, '{ST_STORED,   X0, Y0, X0, Y0, 8'h00, 8'h00, 8'h00}},
    '{8'hFA, 1'b1, '{ST_STORED,   X0, Y0, X0, Y0, 8'h00, 8'h00, 8'h00}},
    '{8'h00, 1'b0, '0},
    '{8'h08, 1'b0, '0},
    '{8'h7F, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'h08, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'h7F, 1'b0, '0},
    '{8'h48, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h88, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFA, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  ps2mct_byte_if                               mouse ();
  ps2mct_cfg_if    #(.COORD_BITS(COORD_BITS))  cfg ();
  ps2mct_result_if #(.COORD_BITS(COORD_BITS))  cursor ();

  ps2_mouse_packet_cursor_tracker #(
    .COORD_BITS  (COORD_BITS),
    .CURSOR_SIZE (CURSOR_SIZE)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .mouse  (mouse),
    .cfg    (cfg),
    .cursor (cursor)
  );

  // Predicted tracker state.
  coord_t     scr_w;
  coord_t     scr_h;
  logic [1:0] pkt_pos;
  logic [7:0] hdr_hold;
  logic [7:0] xd_hold;
  coord_t     cur_x;
  coord_t     cur_y;

  cursor_result_t pending_results[$];
  logic           row_typed;
  cursor_result_t row_want;
  logic           steady_flow;
  int             items_sent;
  int             results_seen;
  int             err_count;
  int             ready_left;
  logic           ready_on;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Move one axis by a signed delta and clamp it to 0 .. size - CURSOR_SIZE.
  function automatic coord_t clamp_axis(input coord_t pos, input int delta, input coord_t size);
    int lim;
    int v;
    lim = int'(size) - CURSOR_SIZE;
    if (lim < 0) lim = 0;
    v = int'(pos) + delta;
    if (v < 0) v = 0;
    if (v > lim) v = lim;
    return coord_t'(v);
  endfunction

  // Advance the predicted packet state by one mouse byte and return the result it causes.
  function automatic cursor_result_t decode_mouse_byte(input logic [7:0] b);
    cursor_result_t r;
    int dx;
    int dy;
    r = '0;
    r.prev_x = cur_x;
    r.prev_y = cur_y;
    if (pkt_pos > POS_LAST) pkt_pos = POS_FIRST;
    if (pkt_pos == POS_FIRST && b == ACK_BYTE) begin
      r.status = ST_ACK;
    end else if (pkt_pos == POS_FIRST && !b[HDR_SYNC_BIT]) begin
      r.status = ST_STRAY;
    end else if (pkt_pos != POS_LAST) begin
      if (pkt_pos == POS_FIRST) hdr_hold = b;
      else xd_hold = b;
      pkt_pos = pkt_pos + 2'd1;
      r.status = ST_STORED;
    end else begin
      r.header_byte = hdr_hold;
      r.x_byte = xd_hold;
      r.y_byte = b;
      pkt_pos = POS_FIRST;
      if ((hdr_hold & OVERFLOW_MASK) == 8'h00) begin
        dx = int'($signed(xd_hold));
        dy = int'($signed(b));
        cur_x = clamp_axis(cur_x, dx, scr_w);
        cur_y = clamp_axis(cur_y, -dy, scr_h);
        r.status = ST_MOVED;
      end else begin
        r.status = ST_OVERFLOW;
      end
    end
    r.cursor_x = cur_x;
    r.cursor_y = cur_y;
    return r;
  endfunction

  function automatic string fmt_result(input cursor_result_t r);
    return $sformatf("status %0d cursor (%0d,%0d) prev (%0d,%0d) bytes %02h %02h %02h",
                     r.status, r.cursor_x, r.cursor_y, r.prev_x, r.prev_y,
                     r.header_byte, r.x_byte, r.y_byte);
  endfunction

  // Random delta byte: sometimes a corner value, often a large step in the drift direction.
  function automatic logic [7:0] pick_delta(input logic toward_positive);
    logic [7:0] corner_vals [0:5];
    int pick;
    corner_vals = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'h81, 8'hFF};
    pick = $urandom_range(0, 9);
    if (pick == 0) return corner_vals[$urandom_range(0, 5)];
    if (pick <= 5) begin
      return toward_positive ? 8'(8'h7F - $urandom_range(0, 31))
                             : 8'(8'h80 + $urandom_range(0, 31));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Result channel back-pressure: random bursts of ready and stall, or ready held high in steady flow.
  always @(posedge clk) begin
    if (steady_flow) begin
      cursor.ready <= 1'b1;
    end else begin
      if (ready_left == 0) begin
        ready_on = ($urandom_range(0, 1) == 1);
        ready_left = ready_on ? $urandom_range(1, 30) : $urandom_range(1, 15);
      end
      cursor.ready <= ready_on;
      ready_left = ready_left - 1;
    end
  end

  // Result checking, register tracking and prediction of every accepted item.
  always @(posedge clk) begin
    cursor_result_t got;
    cursor_result_t want;
    if (rst) begin
      scr_w = coord_t'(RESET_WIDTH);
      scr_h = coord_t'(RESET_HEIGHT);
      pkt_pos = POS_FIRST;
      hdr_hold = 8'h00;
      xd_hold = 8'h00;
      cur_x = scr_w >> 1;
      cur_y = scr_h >> 1;
    end else begin
      if (cursor.valid && cursor.ready) begin
        results_seen++;
        got = '{status_t'(cursor.status), cursor.cursor_x, cursor.cursor_y, cursor.prev_x,
                cursor.prev_y, cursor.header_byte, cursor.x_byte, cursor.y_byte};
        if (pending_results.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("ERROR: result with nothing expected: %s", fmt_result(got));
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            err_count++;
            if (err_count <= MAX_REPORTS) begin
              $display("ERROR: result mismatch at %0t", $realtime);
              $display("  expected %s", fmt_result(want));
              $display("  actual   %s", fmt_result(got));
            end
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_SCREEN_WIDTH) begin
          scr_w = cfg.data;
          cur_x = cfg.data >> 1;
        end else if (cfg.index == REG_SCREEN_HEIGHT) begin
          scr_h = cfg.data;
          cur_y = cfg.data >> 1;
        end
      end
      if (mouse.valid && mouse.ready) begin
        want = decode_mouse_byte(mouse.data_byte);
        if (row_typed) want = row_want;
        pending_results.push_back(want);
      end
    end
  end

  // Send one byte, outside steady flow with an occasional idle burst before it, and wait until it is taken.
  task automatic send_byte(input logic [7:0] value, input logic typed,
                           input cursor_result_t want);
    if (!steady_flow && $urandom_range(0, 3) == 0) begin
      mouse.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    mouse.valid <= 1'b1;
    mouse.data_byte <= value;
    row_typed <= typed;
    row_want <= want;
    @(posedge clk);
    while (!mouse.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_free(input logic [7:0] value);
    send_byte(value, 1'b0, '0);
  endtask

  // Well-formed packet: sync bit set, overflow bits mostly clear, random deltas.
  task automatic send_random_packet(input logic drift_right, input logic drift_up);
    logic [7:0] head;
    head = 8'($urandom_range(0, 255)) | SYNC_MASK;
    if ($urandom_range(0, 99) < 85) head = head & ~OVERFLOW_MASK;
    send_free(head);
    send_free(pick_delta(drift_right));
    send_free(pick_delta(drift_up));
  endtask

  // Bytes outside the packet flow: acknowledges, strays, stray noise and cut-off packets.
  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_free(ACK_BYTE);
      1: send_free(8'($urandom_range(0, 255)) & ~SYNC_MASK);
      2: send_free(8'($urandom_range(0, 255)));
      default: begin
        send_free(8'($urandom_range(0, 255)) | SYNC_MASK);
        send_free(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // Write both size registers once the block is idle, optionally hitting unused indexes.
  task automatic reprogram(input coord_t width, input coord_t height, input logic spare);
    logic [CFG_IDX_BITS-1:0] idx_list [0:3];
    coord_t                  val_list [0:3];
    int                      n;
    while (results_seen != items_sent) @(posedge clk);
    n = 0;
    idx_list[n] = REG_SCREEN_WIDTH;
    val_list[n] = width;
    n++;
    if (spare) begin
      idx_list[n] = REG_SPARE_2;
      val_list[n] = coord_t'($urandom);
      n++;
    end
    idx_list[n] = REG_SCREEN_HEIGHT;
    val_list[n] = height;
    n++;
    if (spare) begin
      idx_list[n] = REG_SPARE_3;
      val_list[n] = coord_t'($urandom);
      n++;
    end
    for (int i = 0; i < n; i++) begin
      cfg.valid <= 1'b1;
      cfg.index <= idx_list[i];
      cfg.data <= val_list[i];
      @(posedge clk);
      while (!cfg.ready) @(posedge clk);
    end
    cfg.valid <= 1'b0;
  endtask

  // Main stimulus.
  initial begin
    coord_t width;
    coord_t height;
    logic   drift_right;
    logic   drift_up;
    int     sent;

    mouse.valid = 1'b0;
    mouse.data_byte = 8'h00;
    cfg.valid = 1'b0;
    cfg.index = REG_SCREEN_WIDTH;
    cfg.data = '0;
    cursor.ready = 1'b0;
    row_typed = 1'b0;
    row_want = '0;
    steady_flow = 1'b0;
    items_sent = 0;
    results_seen = 0;
    err_count = 0;
    ready_left = 0;
    ready_on = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset screen size.
    for (int i = 0; i < $size(DIRECTED_ROWS); i++)
      send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    mouse.valid <= 1'b0;

    // Random part: one screen setting per phase, extremes and tiny screens first.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin width = 13'd0;    height = 13'd8191; end
        1: begin width = 13'd3;    height = 13'd4;    end
        2: begin width = 13'd8191; height = 13'd0;    end
        3: begin width = 13'd4;    height = 13'd5;    end
        4: begin width = 13'd640;  height = 13'd480;  end
        5: begin width = 13'd1;    height = 13'd2;    end
        6: begin width = 13'd8191; height = 13'd8191; end
        default: begin
          width = coord_t'($urandom_range(4, 8191));
          height = coord_t'($urandom_range(0, 8191));
        end
      endcase
      steady_flow <= (ph == NUM_PHASES - 1);
      reprogram(width, height, ph % 3 == 1);
      drift_right = $urandom_range(0, 1);
      drift_up = $urandom_range(0, 1);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 12) begin
          send_noise();
        end else begin
          send_random_packet(drift_right, drift_up);
          sent += 3;
        end
      end
      // In phases with ph % 3 nonzero, leave a packet open so the next size write lands in the middle of it.
      for (int k = 0; k < ph % 3; k++) begin
        if (k == 0) send_free((8'($urandom_range(0, 255)) | SYNC_MASK) & ~OVERFLOW_MASK);
        else send_free(8'($urandom_range(0, 255)));
      end
      mouse.valid <= 1'b0;
    end

    while (results_seen != items_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
